>>> hw/rtl/wfcf_pkg.sv
package wfcf_pkg;

   localparam int NUM_CLASSES = 8;

   typedef enum logic [2:0] {
      RSN_NONE     = 3'd0,
      RSN_LENGTH   = 3'd1,
      RSN_CLASS    = 3'd2,
      RSN_VERSION  = 3'd3,
      RSN_SANITY   = 3'd4,
      RSN_DISABLED = 3'd5,
      RSN_ADDRESS  = 3'd6
   } reason_type;

   typedef enum logic [1:0] {
      CSR_CAPTURE_MASK = 2'd0,
      CSR_TARGET_BSSID = 2'd1,
      CSR_MAX_LENGTH   = 2'd2
   } csr_index_type;

   localparam logic [2:0] CLS_MGMT   = 3'd0;
   localparam logic [2:0] CLS_BEACON = 3'd1;
   localparam logic [2:0] CLS_PREQ   = 3'd2;
   localparam logic [2:0] CLS_PRESP  = 3'd3;
   localparam logic [2:0] CLS_DEAUTH = 3'd4;
   localparam logic [2:0] CLS_CTRL   = 3'd5;
   localparam logic [2:0] CLS_DATA   = 3'd6;
   localparam logic [2:0] CLS_EAPOL  = 3'd7;

   localparam logic [63:0] SNAP_PATTERN = 64'hAAAA_0300_0000_888E;

   // verdict handed from the classifier to the counter stage
   typedef struct packed {
      logic       accepted;
      reason_type reason;
      logic [1:0] frame_type;
      logic [3:0] frame_subtype;
      logic [2:0] frame_class;
   } verdict_type;

endpackage

>>> hw/rtl/wfcf_front.sv
module wfcf_front
   import wfcf_pkg::*;
#(
   parameter int LENGTH_WIDTH = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        frame_byte,
   input  logic              last_byte,
   input  logic [1:0]        rx_class,
   input  logic [6:0]        capture_mask,
   input  logic [47:0]       target_bssid,
   input  logic [11:0]       max_frame_length,
   output logic              vd_valid,
   input  logic              vd_ready,
   output verdict_type       vd_data
);

   localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

   logic [LENGTH_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic [15:0]             fc_ff, fc_in;
   logic [1:0]              hint_ff, hint_in;
   logic [47:0]             ra_ff, ra_in, ta_ff, ta_in, a3_ff, a3_in;
   logic [7:0]              snap_ff [16];
   logic                    vd_valid_ff, vd_valid_in;
   verdict_type             vd_data_ff, vd_data_in;

   logic        take;
   logic [LENGTH_WIDTH:0] len;
   logic [15:0] fc;
   logic [1:0]  ftype;
   logic [3:0]  fsub;
   logic        wds, qos, eapol, off;
   logic [3:0]  hoff;
   logic [63:0] snap_win;
   logic [2:0]  cls;
   reason_type  reason;
   logic        snap_wr;
   logic [3:0]  snap_idx;

   // output slot may be refilled while the queue drains it
   assign in_ready = !vd_valid_ff || vd_ready;
   assign take     = in_valid && in_ready;
   assign vd_valid = vd_valid_ff;
   assign vd_data  = vd_data_ff;
   assign snap_wr  = (byte_count_ff >= LENGTH_WIDTH'(24)) && (byte_count_ff <= LENGTH_WIDTH'(39));
   assign snap_idx = byte_count_ff[3:0] - 4'd8;

   always_comb begin
      byte_count_in = byte_count_ff;
      fc_in   = fc_ff;
      hint_in = hint_ff;
      ra_in   = ra_ff;
      ta_in   = ta_ff;
      a3_in   = a3_ff;
      if (byte_count_ff == '0) begin
         fc_in   = {8'h00, frame_byte};
         hint_in = rx_class;
      end else if (byte_count_ff == LENGTH_WIDTH'(1)) begin
         fc_in = {frame_byte, fc_ff[7:0]};
      end else if (byte_count_ff >= LENGTH_WIDTH'(4) && byte_count_ff <= LENGTH_WIDTH'(9)) begin
         ra_in = {ra_ff[39:0], frame_byte};
      end else if (byte_count_ff >= LENGTH_WIDTH'(10) && byte_count_ff <= LENGTH_WIDTH'(15)) begin
         ta_in = {ta_ff[39:0], frame_byte};
      end else if (byte_count_ff >= LENGTH_WIDTH'(16) && byte_count_ff <= LENGTH_WIDTH'(21)) begin
         a3_in = {a3_ff[39:0], frame_byte};
      end
      if (last_byte)
         byte_count_in = '0;
      else if (byte_count_ff < LEN_MAX)
         byte_count_in = byte_count_ff + LENGTH_WIDTH'(1);
   end

   // verdict for a frame whose last byte is this request
   always_comb begin
      len   = {1'b0, byte_count_ff} + (LENGTH_WIDTH+1)'(1);
      fc    = fc_in;
      ftype = fc[3:2];
      fsub  = fc[7:4];
      wds   = fc[8] && fc[9];
      qos   = fsub[3];
      hoff  = {1'b0, wds, wds, 1'b0} + {2'b00, qos, 1'b0};
      // the current byte may itself be the final snap byte
      for (int i = 0; i < 8; i++) begin
         if (snap_wr && snap_idx == 4'(hoff + 4'(i)))
            snap_win[63-8*i -: 8] = frame_byte;
         else
            snap_win[63-8*i -: 8] = snap_ff[4'(hoff + 4'(i))];
      end
      eapol = (ftype == 2'd2) && (len >= (LENGTH_WIDTH+1)'(36))
              && (len >= (LENGTH_WIDTH+1)'(32) + (LENGTH_WIDTH+1)'(hoff))
              && (snap_win == SNAP_PATTERN);
      case (ftype)
         2'd0: begin
            case (fsub)
               4'd8:        cls = CLS_BEACON;
               4'd4:        cls = CLS_PREQ;
               4'd5:        cls = CLS_PRESP;
               4'd12, 4'd10: cls = CLS_DEAUTH;
               default:     cls = CLS_MGMT;
            endcase
         end
         2'd1:    cls = CLS_CTRL;
         2'd2:    cls = eapol ? CLS_EAPOL : CLS_DATA;
         default: cls = CLS_MGMT;
      endcase
      case (ftype)
         2'd0: off = !capture_mask[0] || (cls == CLS_BEACON && !capture_mask[1])
                     || ((cls == CLS_PREQ || cls == CLS_PRESP) && !capture_mask[2])
                     || (cls == CLS_DEAUTH && !capture_mask[3]);
         2'd1: off = !capture_mask[4];
         2'd2: off = !capture_mask[5] || (eapol && !capture_mask[6]);
         default: off = 1'b1;
      endcase
      if (len < (LENGTH_WIDTH+1)'(24) || len > (LENGTH_WIDTH+1)'(max_frame_length))
         reason = RSN_LENGTH;
      else if (fc[1:0] != 2'd0)
         reason = RSN_VERSION;
      else if (hint_in == 2'd3 || hint_in != ftype)
         reason = RSN_CLASS;
      else if (ftype == 2'd0 && (fsub == 4'd12 || fsub == 4'd10)
               && (len < (LENGTH_WIDTH+1)'(26) || len > (LENGTH_WIDTH+1)'(100) || wds))
         reason = RSN_SANITY;
      else if (ftype == 2'd0 && fc[14] && fsub != 4'd13 && fsub != 4'd14)
         reason = RSN_SANITY;
      else if (off)
         reason = RSN_DISABLED;
      else if (target_bssid != 48'd0 && ra_in != target_bssid && ta_in != target_bssid
               && a3_in != target_bssid)
         reason = RSN_ADDRESS;
      else
         reason = RSN_NONE;
      vd_data_in.accepted      = (reason == RSN_NONE);
      vd_data_in.reason        = reason;
      vd_data_in.frame_type    = ftype;
      vd_data_in.frame_subtype = fsub;
      vd_data_in.frame_class   = cls;
      vd_valid_in = vd_valid_ff && !vd_ready;
      if (take && last_byte)
         vd_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         fc_ff         <= '0;
         hint_ff       <= '0;
         ra_ff         <= '0;
         ta_ff         <= '0;
         a3_ff         <= '0;
         vd_valid_ff   <= 1'b0;
      end else begin
         vd_valid_ff <= vd_valid_in;
         if (take) begin
            byte_count_ff <= byte_count_in;
            fc_ff         <= fc_in;
            hint_ff       <= hint_in;
            ra_ff         <= ra_in;
            ta_ff         <= ta_in;
            a3_ff         <= a3_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && last_byte)
         vd_data_ff <= vd_data_in;
      if (take && snap_wr)
         snap_ff[snap_idx] <= frame_byte;
   end

endmodule

>>> hw/rtl/wfcf_queue.sv
module wfcf_queue
   import wfcf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_valid,
   output logic        wr_ready,
   input  verdict_type wr_data,
   output logic        rd_valid,
   input  logic        rd_ready,
   output verdict_type rd_data
);

   verdict_type slot_ff [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = slot_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wp_ff] <= wr_data;
   end

endmodule

>>> hw/rtl/wfcf_back.sv
module wfcf_back
   import wfcf_pkg::*;
#(
   parameter int COUNTER_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        vd_valid,
   output logic        vd_ready,
   input  verdict_type vd_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_reject_reason,
   output logic [1:0]  rsp_frame_type,
   output logic [3:0]  rsp_frame_subtype,
   output logic [2:0]  rsp_frame_class,
   output logic [31:0] rsp_total_count,
   output logic [31:0] rsp_class_count
);

   logic [COUNTER_WIDTH-1:0] cnt_ff [NUM_CLASSES];
   logic [COUNTER_WIDTH-1:0] total_ff, total_in, cls_in;
   logic                     valid_ff, valid_in;
   verdict_type              out_ff;
   logic [31:0]              tot_out_ff, cls_out_ff;
   logic                     take;

   assign vd_ready = !valid_ff || rsp_ready;
   assign take     = vd_valid && vd_ready;

   always_comb begin
      total_in = total_ff + COUNTER_WIDTH'(vd_data.accepted);
      cls_in   = cnt_ff[vd_data.frame_class] + COUNTER_WIDTH'(vd_data.accepted);
      valid_in = take || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         total_ff <= '0;
         for (int i = 0; i < NUM_CLASSES; i++)
            cnt_ff[i] <= '0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            total_ff <= total_in;
            cnt_ff[vd_data.frame_class] <= cls_in;
         end
      end
   end

   // zero-extend when counters are narrower than the ports
   always_ff @(posedge clock) begin
      if (take) begin
         out_ff     <= vd_data;
         tot_out_ff <= 32'({{64{1'b0}}, total_in});
         cls_out_ff <= 32'({{64{1'b0}}, cls_in});
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_accepted      = out_ff.accepted;
   assign rsp_reject_reason = out_ff.reason;
   assign rsp_frame_type    = out_ff.frame_type;
   assign rsp_frame_subtype = out_ff.frame_subtype;
   assign rsp_frame_class   = out_ff.frame_class;
   assign rsp_total_count   = tot_out_ff;
   assign rsp_class_count   = cls_out_ff;

endmodule

>>> hw/rtl/wlan_frame_classify_filter.sv
// a verdict is registered in the front, queued, then registered for output
// throughput: one byte request per cycle unless stalled (single-byte parser)
// a two-entry verdict queue lets the counter stage stall apart from the parser
// reset (synchronous, active high) clears the parser, queue, counters and
// restores capture_mask 127, target_bssid 0 and max_frame_length 2500
module wlan_frame_classify_filter
   import wfcf_pkg::*;
#(
   parameter int COUNTER_WIDTH = 32,
   parameter int LENGTH_WIDTH  = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   input  logic [1:0]  req_rx_class,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_reject_reason,
   output logic [1:0]  rsp_frame_type,
   output logic [3:0]  rsp_frame_subtype,
   output logic [2:0]  rsp_frame_class,
   output logic [31:0] rsp_total_count,
   output logic [31:0] rsp_class_count,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);

   logic [6:0]  mask_ff;
   logic [47:0] bssid_ff;
   logic [11:0] maxlen_ff;
   logic        fq_valid, fq_ready, qb_valid, qb_ready;
   verdict_type fq_data, qb_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= 7'd127;
         bssid_ff  <= 48'd0;
         maxlen_ff <= 12'd2500;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CAPTURE_MASK: mask_ff   <= csr_data[6:0];
            CSR_TARGET_BSSID: bssid_ff  <= csr_data;
            CSR_MAX_LENGTH:   maxlen_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   wfcf_front #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready),
      .frame_byte(req_frame_byte), .last_byte(req_last_byte), .rx_class(req_rx_class),
      .capture_mask(mask_ff), .target_bssid(bssid_ff), .max_frame_length(maxlen_ff),
      .vd_valid(fq_valid), .vd_ready(fq_ready), .vd_data(fq_data)
   );

   wfcf_queue u_queue (
      .clock, .reset,
      .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
      .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
   );

   wfcf_back #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_back (
      .clock, .reset,
      .vd_valid(qb_valid), .vd_ready(qb_ready), .vd_data(qb_data),
      .rsp_valid, .rsp_ready, .rsp_accepted, .rsp_reject_reason, .rsp_frame_type,
      .rsp_frame_subtype, .rsp_frame_class, .rsp_total_count, .rsp_class_count
   );

endmodule

>>> hw/rtl/wfcf_checker.sv
module wfcf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_accepted,
   input logic [2:0]  rsp_reject_reason,
   input logic [1:0]  rsp_frame_type,
   input logic [2:0]  rsp_frame_class,
   input logic [31:0] rsp_total_count
);

   a_accept_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accepted == (rsp_reject_reason == 3'd0)))
      else $error("accepted flag disagrees with reason");

   a_reason_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reject_reason != 3'd7))
      else $error("reject reason out of range");

   a_ctrl_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_type == 2'd1) |-> (rsp_frame_class == 3'd5))
      else $error("control frame misclassified");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_total_count)))
      else $error("stalled response changed");

endmodule

bind wlan_frame_classify_filter wfcf_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_accepted, .rsp_reject_reason,
   .rsp_frame_type, .rsp_frame_class, .rsp_total_count
);

>>> bench/wfcf_tb_pkg.sv
`timescale 1ns / 100ps

package wfcf_tb_pkg;

   typedef logic [7:0] frame_bytes_type[$];

   // frame control type field
   localparam logic [1:0] FT_MGMT     = 2'd0;
   localparam logic [1:0] FT_CTRL     = 2'd1;
   localparam logic [1:0] FT_DATA     = 2'd2;
   localparam logic [1:0] FT_RESERVED = 2'd3;

   // receiver hint codes
   localparam logic [1:0] HINT_MGMT = 2'd0;
   localparam logic [1:0] HINT_CTRL = 2'd1;
   localparam logic [1:0] HINT_DATA = 2'd2;
   localparam logic [1:0] HINT_MISC = 2'd3;

   // management, data and control subtypes
   localparam logic [3:0] ST_ASSOC_REQ    = 4'd0;
   localparam logic [3:0] ST_PROBE_REQ    = 4'd4;
   localparam logic [3:0] ST_PROBE_RESP   = 4'd5;
   localparam logic [3:0] ST_BEACON       = 4'd8;
   localparam logic [3:0] ST_DISASSOC     = 4'd10;
   localparam logic [3:0] ST_DEAUTH       = 4'd12;
   localparam logic [3:0] ST_ACTION       = 4'd13;
   localparam logic [3:0] ST_ACTION_NOACK = 4'd14;
   localparam logic [3:0] ST_QOS_DATA     = 4'd8;
   localparam logic [3:0] ST_PLAIN_DATA   = 4'd0;
   localparam logic [3:0] ST_ACK          = 4'd13;

   // frame control flag bits (second byte)
   localparam logic [7:0] FLAG_TO_DS     = 8'h01;
   localparam logic [7:0] FLAG_FROM_DS   = 8'h02;
   localparam logic [7:0] FLAG_PROTECTED = 8'h40;

   localparam int HDR_BASIC  = 24;
   localparam int MIN_LENGTH = 24;
   localparam int EAPOL_MIN  = 36;
   localparam int DEAUTH_MIN = 26;
   localparam int DEAUTH_MAX = 100;

endpackage

>>> bench/wfcf_checker.sv
`timescale 1ns / 100ps

module wfcf_scoreboard
   import wfcf_pkg::*;
   import wfcf_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   input  logic [1:0]  req_rx_class,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_accepted,
   input  logic [2:0]  rsp_reject_reason,
   input  logic [1:0]  rsp_frame_type,
   input  logic [3:0]  rsp_frame_subtype,
   input  logic [2:0]  rsp_frame_class,
   input  logic [31:0] rsp_total_count,
   input  logic [31:0] rsp_class_count,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data,
   output int          mismatches,
   output int          outstanding
);

   typedef struct {
      logic        accepted;
      logic [2:0]  reason;
      logic [1:0]  ftype;
      logic [3:0]  fsub;
      logic [2:0]  fclass;
      logic [31:0] total;
      logic [31:0] per_class;
   } verdict_t;

   verdict_t    verdict_q[$];

   logic [6:0]  capture_en;
   logic [47:0] bssid;
   logic [11:0] max_len;
   logic [11:0] byte_pos;
   logic [15:0] fc_word;
   logic [1:0]  hint;
   logic [47:0] addr1, addr2, addr3;
   logic [7:0]  hdr_bytes[16];
   logic [31:0] class_accepts[8];
   logic [31:0] total_accepts;

   initial mismatches = 0;

   function automatic bit carries_eapol(int len);
      int hdr;
      hdr = HDR_BASIC;
      if (fc_word[3:2] != FT_DATA || len < EAPOL_MIN) return 0;
      if (fc_word[8] && fc_word[9]) hdr += 6;
      if (fc_word[7:4] >= 4'd8) hdr += 2;
      if (len < hdr + 8) return 0;
      for (int i = 0; i < 8; i++)
         if (hdr_bytes[(hdr - HDR_BASIC + i) & 15] != SNAP_PATTERN[63 - 8*i -: 8]) return 0;
      return 1;
   endfunction

   task automatic take_byte(logic [7:0] b, logic last, logic [1:0] rx_hint);
      int          pos, len;
      logic [1:0]  ft;
      logic [3:0]  st;
      logic [2:0]  cls, why;
      bit          eapol, off, deauth_like;
      verdict_t    v;
      pos = byte_pos;
      if (pos == 0) begin
         fc_word = {8'h00, b};
         hint = rx_hint;
      end else if (pos == 1) fc_word[15:8] = b;
      else if (pos >= 4 && pos <= 9) addr1 = {addr1[39:0], b};
      else if (pos >= 10 && pos <= 15) addr2 = {addr2[39:0], b};
      else if (pos >= 16 && pos <= 21) addr3 = {addr3[39:0], b};
      else if (pos >= 24 && pos <= 39) hdr_bytes[pos - 24] = b;
      if (!last) begin
         if (byte_pos != 12'hFFF) byte_pos++;
         return;
      end
      byte_pos = 0;
      len = pos + 1;
      ft = fc_word[3:2];
      st = fc_word[7:4];
      eapol = carries_eapol(len);
      deauth_like = (st == ST_DEAUTH || st == ST_DISASSOC);
      if (ft == FT_MGMT) begin
         if (st == ST_BEACON) cls = CLS_BEACON;
         else if (st == ST_PROBE_REQ) cls = CLS_PREQ;
         else if (st == ST_PROBE_RESP) cls = CLS_PRESP;
         else if (deauth_like) cls = CLS_DEAUTH;
         else cls = CLS_MGMT;
      end else if (ft == FT_CTRL) cls = CLS_CTRL;
      else if (ft == FT_DATA) cls = eapol ? CLS_EAPOL : CLS_DATA;
      else cls = CLS_MGMT;

      why = RSN_NONE;
      if (len < MIN_LENGTH || len > max_len) why = RSN_LENGTH;
      else if (fc_word[1:0] != 2'd0) why = RSN_VERSION;
      else if (hint == HINT_MISC || hint != ft) why = RSN_CLASS;
      else if (ft == FT_MGMT && deauth_like &&
               (len < DEAUTH_MIN || len > DEAUTH_MAX || (fc_word[8] && fc_word[9])))
         why = RSN_SANITY;
      else if (ft == FT_MGMT && fc_word[14] && st != ST_ACTION && st != ST_ACTION_NOACK)
         why = RSN_SANITY;
      else begin
         if (ft == FT_MGMT)
            off = !capture_en[0] || (cls == CLS_BEACON && !capture_en[1]) ||
                  ((cls == CLS_PREQ || cls == CLS_PRESP) && !capture_en[2]) ||
                  (cls == CLS_DEAUTH && !capture_en[3]);
         else if (ft == FT_CTRL) off = !capture_en[4];
         else if (ft == FT_DATA) off = !capture_en[5] || (eapol && !capture_en[6]);
         else off = 1;
         if (off) why = RSN_DISABLED;
         else if (bssid != 0 && addr1 != bssid && addr2 != bssid && addr3 != bssid)
            why = RSN_ADDRESS;
      end
      if (why == RSN_NONE) begin
         total_accepts++;
         class_accepts[cls]++;
      end
      v.accepted = (why == RSN_NONE);
      v.reason = why;
      v.ftype = ft;
      v.fsub = st;
      v.fclass = cls;
      v.total = total_accepts;
      v.per_class = class_accepts[cls];
      verdict_q.push_back(v);
   endtask

   task automatic check_verdict();
      verdict_t v;
      if (verdict_q.size() == 0) begin
         $error("verdict with no frame pending");
         mismatches++;
         return;
      end
      v = verdict_q.pop_front();
      if (rsp_accepted !== v.accepted) begin
         $error("accepted: expected %0d, got %0d", v.accepted, rsp_accepted);
         mismatches++;
      end
      if (rsp_reject_reason !== v.reason) begin
         $error("reject_reason: expected %0d, got %0d", v.reason, rsp_reject_reason);
         mismatches++;
      end
      if (rsp_frame_type !== v.ftype) begin
         $error("frame_type: expected %0d, got %0d", v.ftype, rsp_frame_type);
         mismatches++;
      end
      if (rsp_frame_subtype !== v.fsub) begin
         $error("frame_subtype: expected %0d, got %0d", v.fsub, rsp_frame_subtype);
         mismatches++;
      end
      if (rsp_frame_class !== v.fclass) begin
         $error("frame_class: expected %0d, got %0d", v.fclass, rsp_frame_class);
         mismatches++;
      end
      if (rsp_total_count !== v.total) begin
         $error("total_count: expected %0d, got %0d", v.total, rsp_total_count);
         mismatches++;
      end
      if (rsp_class_count !== v.per_class) begin
         $error("class_count: expected %0d, got %0d", v.per_class, rsp_class_count);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         capture_en = 7'd127;
         bssid = '0;
         max_len = 12'd2500;
         byte_pos = '0;
         fc_word = '0;
         hint = '0;
         addr1 = '0;
         addr2 = '0;
         addr3 = '0;
         total_accepts = '0;
         for (int i = 0; i < 16; i++) hdr_bytes[i] = '0;
         for (int i = 0; i < 8; i++) class_accepts[i] = '0;
         verdict_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_CAPTURE_MASK: capture_en = csr_data[6:0];
               CSR_TARGET_BSSID: bssid = csr_data;
               CSR_MAX_LENGTH:   max_len = csr_data[11:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) take_byte(req_frame_byte, req_last_byte, req_rx_class);
         if (rsp_valid && rsp_ready) check_verdict();
      end
      outstanding <= verdict_q.size();
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import wfcf_pkg::*;
   import wfcf_tb_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_frame_byte = '0;
   logic        req_last_byte = 1'b0;
   logic [1:0]  req_rx_class = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_accepted;
   logic [2:0]  rsp_reject_reason;
   logic [1:0]  rsp_frame_type;
   logic [3:0]  rsp_frame_subtype;
   logic [2:0]  rsp_frame_class;
   logic [31:0] rsp_total_count;
   logic [31:0] rsp_class_count;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [47:0] csr_data = '0;

   int          mismatches;
   int          pending;
   int          send_idle_pct = 13;
   int          recv_stall_pct = 79;
   int          hold_left = 0;
   bit          hold_request = 0;
   int          quiet_cycles = 0;
   logic [47:0] cur_bssid = '0;

   wlan_frame_classify_filter dut (.*);

   wfcf_scoreboard u_scoreboard (
      .clock, .reset, .req_valid, .req_ready, .req_frame_byte, .req_last_byte,
      .req_rx_class, .rsp_valid, .rsp_ready, .rsp_accepted, .rsp_reject_reason,
      .rsp_frame_type, .rsp_frame_subtype, .rsp_frame_class, .rsp_total_count,
      .rsp_class_count, .csr_write, .csr_index, .csr_data,
      .mismatches, .outstanding(pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // verdict side, with a long hold-off when hold_request is set
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_frame(input frame_bytes_type f, input logic [1:0] hint);
      for (int i = 0; i < f.size(); i++) begin
         if ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_frame_byte <= f[i];
         req_last_byte <= (i == f.size() - 1);
         req_rx_class <= (i == 0) ? hint : 2'($urandom_range(3));
         @(posedge clock);
         while (!req_ready) @(posedge clock);
      end
   endtask

   // called right after an accepted byte, before any wait
   task automatic release_request_line();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_verdicts();
      release_request_line();
      while (pending != 0) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [6:0] mask, input logic [47:0] bssid,
                                 input logic [11:0] max_len);
      wait_for_verdicts();
      repeat (6) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_CAPTURE_MASK;
      csr_data <= 48'(mask);
      @(posedge clock);
      csr_index <= CSR_TARGET_BSSID;
      csr_data <= bssid;
      @(posedge clock);
      csr_index <= CSR_MAX_LENGTH;
      csr_data <= 48'(max_len);
      @(posedge clock);
      csr_write <= 1'b0;
      cur_bssid = bssid;
   endtask

   task automatic make_frame(input logic [1:0] ft, input logic [3:0] st,
                             input logic [7:0] flags, input int len, input bit snap,
                             input logic [1:0] version, output frame_bytes_type f);
      int hdr, slot;
      f = {};
      for (int i = 0; i < len; i++) f.push_back(8'($urandom));
      f[0] = {st, ft, version};
      if (len > 1) f[1] = flags;
      if (cur_bssid != 0 && $urandom_range(3) != 0) begin
         slot = 4 + 6 * $urandom_range(2);
         if (len > slot + 5)
            for (int i = 0; i < 6; i++) f[slot + i] = cur_bssid[47 - 8*i -: 8];
      end
      hdr = HDR_BASIC + ((flags[0] && flags[1]) ? 6 : 0) + ((st >= 4'd8) ? 2 : 0);
      if (snap && len >= hdr + 8)
         for (int i = 0; i < 8; i++) f[hdr + i] = SNAP_PATTERN[63 - 8*i -: 8];
   endtask

   task automatic directed(input logic [1:0] ft, input logic [3:0] st, input logic [7:0] flags,
                           input int len, input bit snap, input logic [1:0] version,
                           input logic [1:0] hint);
      frame_bytes_type f;
      make_frame(ft, st, flags, len, snap, version, f);
      send_frame(f, hint);
   endtask

   task automatic random_frame();
      frame_bytes_type f;
      logic [1:0] ft, hint, version;
      logic [3:0] st;
      logic [7:0] flags;
      int         pick, len;
      pick = $urandom_range(99);
      ft = pick < 45 ? FT_MGMT : pick < 60 ? FT_CTRL : pick < 95 ? FT_DATA : FT_RESERVED;
      st = 4'($urandom);
      flags = 8'($urandom);
      if (ft == FT_MGMT) begin
         case ($urandom_range(7))
            0: st = ST_BEACON;
            1: st = ST_PROBE_REQ;
            2: st = ST_PROBE_RESP;
            3: st = ST_DEAUTH;
            4: st = ST_DISASSOC;
            5: st = ST_ACTION;
            6: st = ST_ACTION_NOACK;
            default: ;
         endcase
         if ($urandom_range(4) != 0) flags &= ~FLAG_PROTECTED;
         if ($urandom_range(3) != 0) flags &= ~(FLAG_TO_DS | FLAG_FROM_DS);
      end
      pick = $urandom_range(99);
      len = pick < 70 ? $urandom_range(24, 48) : pick < 85 ? $urandom_range(1, 23)
                                                          : $urandom_range(49, 120);
      version = ($urandom_range(9) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
      hint = ($urandom_range(99) < 85 && ft != FT_RESERVED) ? ft : 2'($urandom_range(3));
      make_frame(ft, st, flags, len, (ft == FT_DATA && $urandom_range(9) < 7), version, f);
      send_frame(f, hint);
   endtask

   initial begin
      frame_bytes_type f;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames under the reset settings
      directed(FT_MGMT, ST_BEACON, 8'h00, 40, 0, 2'd0, HINT_MGMT);
      directed(FT_MGMT, ST_PROBE_REQ, 8'h00, 30, 0, 2'd0, HINT_MGMT);
      directed(FT_MGMT, ST_PROBE_RESP, 8'h00, 60, 0, 2'd0, HINT_MGMT);
      directed(FT_MGMT, ST_DEAUTH, 8'h00, 26, 0, 2'd0, HINT_MGMT);
      directed(FT_MGMT, ST_DISASSOC, 8'h00, 25, 0, 2'd0, HINT_MGMT);
      directed(FT_MGMT, ST_DEAUTH, 8'h00, 101, 0, 2'd0, HINT_MGMT);
      directed(FT_MGMT, ST_DISASSOC, FLAG_TO_DS | FLAG_FROM_DS, 40, 0, 2'd0, HINT_MGMT);
      directed(FT_MGMT, ST_ACTION, FLAG_PROTECTED, 30, 0, 2'd0, HINT_MGMT);
      directed(FT_MGMT, ST_BEACON, FLAG_PROTECTED, 30, 0, 2'd0, HINT_MGMT);
      directed(FT_CTRL, ST_ACK, 8'h00, 24, 0, 2'd0, HINT_CTRL);
      directed(FT_DATA, ST_PLAIN_DATA, 8'h00, 50, 1, 2'd0, HINT_DATA);
      directed(FT_DATA, ST_QOS_DATA, 8'h00, 50, 1, 2'd0, HINT_DATA);
      // four-address qos header just long enough for the snap header
      directed(FT_DATA, ST_QOS_DATA, FLAG_TO_DS | FLAG_FROM_DS, 40, 1, 2'd0, HINT_DATA);
      directed(FT_DATA, ST_PLAIN_DATA, 8'h00, 35, 1, 2'd0, HINT_DATA);
      directed(FT_DATA, ST_PLAIN_DATA, 8'h00, 36, 0, 2'd0, HINT_DATA);
      directed(FT_DATA, ST_PLAIN_DATA, 8'h00, 1, 0, 2'd0, HINT_DATA);
      directed(FT_MGMT, ST_BEACON, 8'h00, 23, 0, 2'd0, HINT_MGMT);
      directed(FT_RESERVED, ST_BEACON, 8'h00, 30, 0, 2'd0, HINT_MISC);
      directed(FT_MGMT, ST_BEACON, 8'h00, 30, 0, 2'd1, HINT_MGMT);
      directed(FT_MGMT, ST_BEACON, 8'h00, 30, 0, 2'd0, HINT_MISC);
      directed(FT_DATA, ST_PLAIN_DATA, 8'h00, 30, 0, 2'd0, HINT_CTRL);
      f = {};
      for (int i = 0; i < 24; i++) f.push_back(8'hFF);
      send_frame(f, HINT_MISC);
      f = {};
      for (int i = 0; i < 24; i++) f.push_back(8'h00);
      send_frame(f, HINT_MGMT);

      apply_settings(7'd127, 48'h0, 12'd4095);
      for (int i = 0; i < 2; i++) random_frame();
      // long verdict hold-off while single-byte frames pile up
      hold_request = 1;
      for (int i = 0; i < 12; i++) directed(FT_DATA, ST_PLAIN_DATA, 8'h00, 1, 0, 2'd0, HINT_DATA);
      wait_for_verdicts();
      random_frame();

      send_idle_pct = 79;
      recv_stall_pct = 13;
      apply_settings(7'($urandom), 48'h0200_1122_3344, 12'd24);
      random_frame();
      apply_settings(7'd0, 48'h0, 12'd100);
      random_frame();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      apply_settings(7'd127, 48'hFFFF_FFFF_FFFF, 12'd2500);
      random_frame();
      apply_settings(7'($urandom), 48'({$urandom, $urandom}), 12'($urandom_range(24, 4095)));
      random_frame();
      apply_settings(7'($urandom), 48'h0A0B_0C0D_0E0F, 12'($urandom_range(24, 200)));
      random_frame();

      wait_for_verdicts();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
